FILE: sv/gcc_pkg.sv
package gcc_pkg;

  localparam int unsigned ValW       = 32;
  localparam int unsigned MAX_DENOMS = 32;

  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StWait,
    StSel,
    StDiv,
    StEmitRd,
    StEmit
  } state_e;

  typedef struct packed {
    logic            done;
    logic [ValW-1:0] quot;
    logic [ValW-1:0] rem;
  } div_res_t;

endpackage

FILE: sv/gcc_if.sv
interface gcc_in_if;
  logic                     valid;
  logic                     ready;
  logic                     mode;
  logic [gcc_pkg::ValW-1:0] value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

interface gcc_out_if;
  logic                     valid;
  logic                     ready;
  logic [gcc_pkg::ValW-1:0] coin_count;
  logic                     possible;
  logic                     last;

  modport source (output valid, output coin_count, output possible, output last, input ready);
  modport sink   (input valid, input coin_count, input possible, input last, output ready);
endinterface

FILE: sv/gcc_div.sv
module gcc_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [gcc_pkg::ValW-1:0] dividend_i,
  input  logic [gcc_pkg::ValW-1:0] divisor_i,
  output logic                     busy_o,
  output gcc_pkg::div_res_t        res_o
);
  import gcc_pkg::*;

  localparam int unsigned StepW = $clog2(ValW);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [StepW-1:0] step_q, step_d;
  logic [ValW-1:0]  quo_q, quo_d;
  logic [ValW-1:0]  rem_q, rem_d;
  logic [ValW-1:0]  dvs_q, dvs_d;
  logic [ValW:0]    shifted;
  logic [ValW:0]    diff;
  logic             ge;

  // one restoring step per cycle
  always_comb begin
    shifted = {rem_q, quo_q[ValW-1]};
    ge      = shifted >= {1'b0, dvs_q};
    diff    = shifted - {1'b0, dvs_q};
    busy_d  = busy_q;
    done_d  = 1'b0;
    step_d  = step_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      step_d = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      quo_d  = {quo_q[ValW-2:0], ge};
      rem_d  = ge ? diff[ValW-1:0] : shifted[ValW-1:0];
      step_d = step_q + StepW'(1);
      if (step_q == StepW'(ValW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign busy_o     = busy_q;
  assign res_o.done = done_q;
  assign res_o.quot = quo_q;
  assign res_o.rem  = rem_q;

endmodule

FILE: sv/greedy_coin_change_top.sv
// Greedy coin change. A mode 0 transfer loads one nonzero denomination (zero values and
// loads past MaxDenoms are dropped). A mode 1 transfer gives the amount: for each of the n
// loaded denominations the sequencer scans the denomination memory for the largest unused
// value (first loaded wins a tie), then divides the remaining amount by it in a shared
// 32-step restoring divider, or records zero coins if it is too large. Input ready stays
// low until the last result has been taken. Results come out in load order with possible
// high and last on the final one, or as one result with coin_count zero when the amount
// cannot be met or nothing was loaded. The list is then empty again.
module greedy_coin_change_top #(
  parameter int unsigned MaxDenoms = gcc_pkg::MAX_DENOMS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  gcc_in_if.sink    in_i,
  gcc_out_if.source out_o
);
  import gcc_pkg::*;

  localparam int unsigned IdxW = (MaxDenoms > 1) ? $clog2(MaxDenoms) : 1;
  localparam int unsigned CntW = $clog2(MaxDenoms + 1);

  state_e             state_q, state_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [CntW-1:0]    n_q, n_d;
  logic [CntW-1:0]    n_m1;
  logic [IdxW-1:0]    last_idx;
  logic [IdxW-1:0]    scan_q, scan_d;
  logic [IdxW-1:0]    round_q, round_d;
  logic [IdxW-1:0]    out_idx_q, out_idx_d;
  logic [IdxW-1:0]    rd_idx_q, rd_idx_d;
  logic               rd_vld_q, rd_vld_d;
  logic [MaxDenoms-1:0] used_q, used_d;
  logic               best_vld_q, best_vld_d;
  logic [IdxW-1:0]    best_idx_q, best_idx_d;
  logic [ValW-1:0]    best_val_q, best_val_d;
  logic [ValW-1:0]    rem_q, rem_d;
  logic               zero_q, zero_d;
  logic               poss_q, poss_d;
  logic               advance;
  logic               out_last;

  logic [ValW-1:0]    den_mem [MaxDenoms];
  logic [ValW-1:0]    cnt_mem [MaxDenoms];
  logic [ValW-1:0]    den_rd_q;
  logic [ValW-1:0]    cnt_rd_q;
  logic               den_we, den_re, cnt_we, cnt_re;
  logic [ValW-1:0]    cnt_wdata;

  logic               div_start;
  logic               div_busy;
  div_res_t           div_res;

  gcc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (rem_q),
    .divisor_i  (best_val_q),
    .busy_o     (div_busy),
    .res_o      (div_res)
  );

  assign n_m1     = n_q - CntW'(1);
  assign last_idx = n_m1[IdxW-1:0];
  assign out_last = zero_q || (out_idx_q == last_idx);

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    n_d        = n_q;
    scan_d     = scan_q;
    round_d    = round_q;
    out_idx_d  = out_idx_q;
    rd_idx_d   = scan_q;
    rd_vld_d   = 1'b0;
    used_d     = used_q;
    best_vld_d = best_vld_q;
    best_idx_d = best_idx_q;
    best_val_d = best_val_q;
    rem_d      = rem_q;
    zero_d     = zero_q;
    poss_d     = poss_q;
    advance    = 1'b0;
    den_we     = 1'b0;
    den_re     = 1'b0;
    cnt_we     = 1'b0;
    cnt_re     = 1'b0;
    cnt_wdata  = '0;
    div_start  = 1'b0;

    // running maximum over the scanned entries
    if (rd_vld_q && !used_q[rd_idx_q] && (!best_vld_q || den_rd_q > best_val_q)) begin
      best_vld_d = 1'b1;
      best_val_d = den_rd_q;
      best_idx_d = rd_idx_q;
    end

    case (state_q)
      StIdle: begin
        if (in_i.valid) begin
          if (!in_i.mode) begin
            if (in_i.value != '0 && cnt_q < CntW'(MaxDenoms)) begin
              den_we = 1'b1;
              cnt_d  = cnt_q + CntW'(1);
            end
          end else begin
            rem_d  = in_i.value;
            n_d    = cnt_q;
            cnt_d  = '0;
            used_d = '0;
            if (cnt_q == '0) begin
              zero_d  = 1'b1;
              poss_d  = (in_i.value == '0);
              state_d = StEmit;
            end else begin
              zero_d     = 1'b0;
              poss_d     = 1'b1;
              round_d    = '0;
              scan_d     = '0;
              best_vld_d = 1'b0;
              state_d    = StScan;
            end
          end
        end
      end
      StScan: begin
        den_re   = 1'b1;
        rd_vld_d = 1'b1;
        if (scan_q == last_idx) begin
          state_d = StWait;
        end else begin
          scan_d = scan_q + IdxW'(1);
        end
      end
      StWait: begin
        state_d = StSel;
      end
      StSel: begin
        used_d[best_idx_q] = 1'b1;
        if (best_val_q <= rem_q) begin
          div_start = 1'b1;
          state_d   = StDiv;
        end else begin
          cnt_we  = 1'b1;
          advance = 1'b1;
        end
      end
      StDiv: begin
        if (div_res.done) begin
          cnt_we    = 1'b1;
          cnt_wdata = div_res.quot;
          rem_d     = div_res.rem;
          advance   = 1'b1;
        end
      end
      StEmitRd: begin
        cnt_re  = 1'b1;
        state_d = StEmit;
      end
      StEmit: begin
        if (out_o.ready) begin
          if (out_last) begin
            state_d = StIdle;
          end else begin
            out_idx_d = out_idx_q + IdxW'(1);
            state_d   = StEmitRd;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    if (advance) begin
      if (round_q == last_idx) begin
        if (rem_d != '0) begin
          zero_d  = 1'b1;
          poss_d  = 1'b0;
          state_d = StEmit;
        end else begin
          out_idx_d = '0;
          state_d   = StEmitRd;
        end
      end else begin
        round_d    = round_q + IdxW'(1);
        scan_d     = '0;
        best_vld_d = 1'b0;
        state_d    = StScan;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      cnt_q      <= '0;
      n_q        <= '0;
      scan_q     <= '0;
      round_q    <= '0;
      out_idx_q  <= '0;
      rd_vld_q   <= 1'b0;
      used_q     <= '0;
      best_vld_q <= 1'b0;
      zero_q     <= 1'b0;
      poss_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      n_q        <= n_d;
      scan_q     <= scan_d;
      round_q    <= round_d;
      out_idx_q  <= out_idx_d;
      rd_vld_q   <= rd_vld_d;
      used_q     <= used_d;
      best_vld_q <= best_vld_d;
      zero_q     <= zero_d;
      poss_q     <= poss_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q   <= rd_idx_d;
    best_idx_q <= best_idx_d;
    best_val_q <= best_val_d;
    rem_q      <= rem_d;
  end

  // denomination memory
  always_ff @(posedge clk_i) begin
    if (den_we) begin
      den_mem[cnt_q[IdxW-1:0]] <= in_i.value;
    end
    if (den_re) begin
      den_rd_q <= den_mem[scan_q];
    end
  end

  // coin count memory, load order
  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[best_idx_q] <= cnt_wdata;
    end
    if (cnt_re) begin
      cnt_rd_q <= cnt_mem[out_idx_q];
    end
  end

  assign in_i.ready       = (state_q == StIdle);
  assign out_o.valid      = (state_q == StEmit);
  assign out_o.coin_count = zero_q ? '0 : cnt_rd_q;
  assign out_o.possible   = poss_q;
  assign out_o.last       = out_last;

  a_no_overlap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_i.ready && out_o.valid))
    else $error("input taken while a result is pending");

  a_div_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_div_rem : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_res.done |-> (div_res.rem < best_val_q))
    else $error("remainder not below divisor");

  a_last_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && out_o.last) |=> in_i.ready)
    else $error("not ready after final transfer");

endmodule

FILE: sim/gcc_tb_pkg.sv
`timescale 1ns / 100ps
package gcc_tb_pkg;

  typedef enum logic {
    ModeLoad   = 1'b0,
    ModeAmount = 1'b1
  } mode_e;

  typedef struct packed {
    logic [gcc_pkg::ValW-1:0] coin_count;
    logic                     possible;
    logic                     last;
  } coin_result_t;

endpackage

FILE: sim/gcc_change_checker.sv
`timescale 1ns / 100ps
module gcc_change_checker (
  input  logic clk_i,
  input  logic rst_ni,
  gcc_in_if    in_i,
  gcc_out_if   res_i,
  output int   fail_count_o,
  output int   outstanding_o
);
  import gcc_pkg::*;
  import gcc_tb_pkg::*;

  logic [ValW-1:0] denoms [MAX_DENOMS];
  int              loaded;
  int              fails;
  coin_result_t    expected_coins [$];

  // largest unused denomination first, earliest load wins a tie
  task automatic predict_change(input logic [ValW-1:0] amount);
    logic [ValW-1:0] rest;
    logic [ValW-1:0] counts [MAX_DENOMS];
    bit              used [MAX_DENOMS];
    int              pick;
    int              i;
    int              round;
    coin_result_t    r;
    rest = amount;
    for (i = 0; i < loaded; i++) begin
      counts[i] = '0;
      used[i]   = 1'b0;
    end
    for (round = 0; round < loaded; round++) begin
      pick = -1;
      for (i = 0; i < loaded; i++) begin
        if (!used[i] && (pick < 0 || denoms[i] > denoms[pick])) begin
          pick = i;
        end
      end
      used[pick] = 1'b1;
      if (denoms[pick] <= rest) begin
        counts[pick] = rest / denoms[pick];
        rest         = rest % denoms[pick];
      end
    end
    if (rest != 0 || loaded == 0) begin
      r.coin_count = '0;
      r.possible   = (rest == 0);
      r.last       = 1'b1;
      expected_coins.push_back(r);
    end else begin
      for (i = 0; i < loaded; i++) begin
        r.coin_count = counts[i];
        r.possible   = 1'b1;
        r.last       = (i == loaded - 1);
        expected_coins.push_back(r);
      end
    end
    loaded = 0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    coin_result_t want;
    if (!rst_ni) begin
      loaded = 0;
      fails  = 0;
      expected_coins.delete();
      fail_count_o  <= 0;
      outstanding_o <= 0;
    end else begin
      if (res_i.valid && res_i.ready) begin
        if (expected_coins.size() == 0) begin
          $display("%0t: unexpected result, coin_count %0h possible %0b last %0b",
                   $time, res_i.coin_count, res_i.possible, res_i.last);
          fails++;
        end else begin
          want = expected_coins.pop_front();
          if (res_i.coin_count !== want.coin_count) begin
            $display("%0t: coin_count expected %0h actual %0h",
                     $time, want.coin_count, res_i.coin_count);
            fails++;
          end
          if (res_i.possible !== want.possible) begin
            $display("%0t: possible expected %0b actual %0b",
                     $time, want.possible, res_i.possible);
            fails++;
          end
          if (res_i.last !== want.last) begin
            $display("%0t: last expected %0b actual %0b", $time, want.last, res_i.last);
            fails++;
          end
        end
      end
      if (in_i.valid && in_i.ready) begin
        if (in_i.mode == ModeLoad) begin
          if (in_i.value != 0 && loaded < MAX_DENOMS) begin
            denoms[loaded] = in_i.value;
            loaded++;
          end
        end else begin
          predict_change(in_i.value);
        end
      end
      fail_count_o  <= fails;
      outstanding_o <= expected_coins.size();
    end
  end

endmodule

FILE: sim/greedy_coin_change_top_tb.sv
`timescale 1ns / 100ps
module greedy_coin_change_top_tb;
  import gcc_tb_pkg::*;

  localparam int IdleLimit   = 20000;
  localparam int RandomItems = 230;
  localparam int SettleWait  = 100;

  logic clk_i;
  logic rst_ni;
  bit   steady;
  int   fail_count;
  int   outstanding;
  int   idle_cycles;
  int   taken_items;
  int   held;

  gcc_in_if  in_if ();
  gcc_out_if out_if ();

  greedy_coin_change_top uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  gcc_change_checker change_chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_i          (in_if),
    .res_i         (out_if),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  task automatic send_item(input mode_e item_mode, input logic [31:0] item_value);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.mode  <= item_mode;
    in_if.value <= item_value;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    if (item_mode == ModeAmount) begin
      held = 0;
      taken_items++;
    end else if (item_value != 0 && held < gcc_pkg::MAX_DENOMS) begin
      held++;
      taken_items++;
    end
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] draw_denom();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      return '0;
    end else if (sel <= 4) begin
      return $urandom_range(1, 20);
    end else if (sel <= 6) begin
      return 32'd1 << $urandom_range(0, 31);
    end
    return $urandom;
  endfunction

  // loads with random content, then one amount
  task automatic random_run();
    int          n;
    int          k;
    int          sel;
    logic [31:0] d;
    logic [31:0] amount;
    steady = ($urandom_range(0, 4) == 0);
    n      = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 36) : $urandom_range(0, 6);
    amount = '0;
    for (k = 0; k < n; k++) begin
      d = draw_denom();
      send_item(ModeLoad, d);
      amount += d * $urandom_range(0, 3);
    end
    sel = $urandom_range(0, 9);
    case (sel)
      0: begin
        amount = '0;
      end
      1: begin
        amount = '1;
      end
      2, 3: begin
        amount = $urandom;
      end
      4: begin
        amount = $urandom_range(0, 100);
      end
      default: begin
      end
    endcase
    if ($urandom_range(0, 7) == 0) begin
      drain();
    end
    send_item(ModeAmount, amount);
  endtask

  initial begin
    out_if.ready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      int stall;
      stall = steady ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_if.valid) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("greedy_coin_change_top verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    in_if.valid <= 1'b0;
    in_if.mode  <= ModeLoad;
    in_if.value <= '0;
    rst_ni      <= 1'b0;
    steady      = 1'b0;
    held        = 0;
    taken_items = 0;
    idle_cycles = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty list, zero and nonzero amount
    send_item(ModeAmount, 32'd0);
    send_item(ModeAmount, 32'd5);
    // zero denomination skipped, full-scale amount in ones
    send_item(ModeLoad, 32'd0);
    send_item(ModeLoad, 32'd1);
    send_item(ModeAmount, 32'hFFFF_FFFF);
    drain();
    send_item(ModeLoad, 32'hFFFF_FFFF);
    send_item(ModeLoad, 32'd1);
    send_item(ModeAmount, 32'hFFFF_FFFF);
    // equal values keep load order
    send_item(ModeLoad, 32'd3);
    send_item(ModeLoad, 32'd5);
    send_item(ModeLoad, 32'd3);
    send_item(ModeAmount, 32'd13);
    // remainder left
    send_item(ModeLoad, 32'd4);
    send_item(ModeAmount, 32'd6);
    // denomination above the amount
    send_item(ModeLoad, 32'd10);
    send_item(ModeLoad, 32'd1);
    send_item(ModeAmount, 32'd3);
    send_item(ModeLoad, 32'd7);
    send_item(ModeAmount, 32'd0);
    send_item(ModeLoad, 32'h8000_0000);
    send_item(ModeLoad, 32'h7FFF_FFFF);
    send_item(ModeAmount, 32'hFFFF_FFFF);

    taken_items = 0;
    while (taken_items < RandomItems) random_run();
    in_if.valid <= 1'b0;

    drain();
    repeat (SettleWait) @(posedge clk_i);
    if (fail_count == 0 && outstanding == 0) begin
      $display("greedy_coin_change_top verification clean");
    end else begin
      $display("greedy_coin_change_top verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/gcc_pkg.sv
sv/gcc_if.sv
sv/gcc_div.sv
sv/greedy_coin_change_top.sv
sim/gcc_tb_pkg.sv
sim/gcc_change_checker.sv
sim/greedy_coin_change_top_tb.sv
